// ===== design/gfc_pkg.sv =====
// Shared types and codes for the frame compositor.
// No dependencies.
package gfc_pkg;

    typedef enum logic [1:0] {
        KIND_PAL   = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_PIX   = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        DISP_NONE    = 2'd0,
        DISP_KEEP    = 2'd1,
        DISP_BG      = 2'd2,
        DISP_RESTORE = 2'd3
    } disp_t;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hff000000;

endpackage

// ===== design/gif_frame_compositor_top.sv =====
// Frame compositor top: sequencer over screen and save memories.
// Depends on gfc_pkg and gfc_mem.
//
// Usage: an item is taken when start is high and busy is low. Every item yields one
// result: done strobes for one cycle with pixel and done_res on the result ports;
// the receiver cannot stall. Palette writes and frame begins with nothing to walk
// go from accept through S_DONE to the result cycle; raster pixels go through
// decode, memory write (S_PIX), S_DONE and result, and reads through S_READ
// (memory read), S_DONE (output register) and result. The next item can be
// taken at the edge that ends the result cycle. A frame begin that needs disposal
// or a save walks a rectangle one pixel at a time through the memories (read then
// write for copies, write only for clears); a first-frame clear sweeps every
// MAX_SIDE*MAX_SIDE entry. After reset the block sweeps the whole screen memory
// clearing it with busy high; configuration writes are taken at any time via
// cfg_valid/cfg_ready, index cfg_index, data cfg_data.
// Items are handled one at a time; busy stays high until the result cycle.
module gif_frame_compositor_top #(
    parameter int MAX_SIDE        = 256,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [7:0]         color_index,
    input  logic [23:0]        rgb,
    input  logic [15:0]        left,
    input  logic [15:0]        top,
    input  logic [15:0]        rect_width,
    input  logic [15:0]        rect_height,
    input  logic [1:0]         disposal,
    input  logic signed [8:0]  transparent_index,
    input  logic               first_frame,
    input  logic [8:0]         color_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    output logic               done,
    output logic [31:0]        pixel,
    output logic               done_res
);

    localparam int SW = $clog2(MAX_SIDE);
    localparam int AW = 2 * SW;
    localparam int PW = $clog2(PALETTE_ENTRIES);
    localparam int CW = $clog2(MAX_SIDE + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_READ, S_PIX, S_DSP_RD, S_DSP_WR, S_SAVE_RD, S_SAVE_WR, S_DONE
    } state_t;

    state_t state_reg;

    logic [CW-1:0] sw_reg, sh_reg;
    logic [23:0]   pal [PALETTE_ENTRIES];
    logic [8:0]    plimit_reg;
    logic [1:0]    pdisp_reg;
    logic [CW-1:0] px0_reg, py0_reg, px1_reg, py1_reg;
    logic [15:0]   gl_reg, gt_reg, gw_reg, gh_reg;
    logic [15:0]   cx_reg, cy_reg;
    logic signed [8:0] tr_reg;
    logic          clr_all_reg, restore_reg, save_reg;
    logic [CW-1:0] wx_reg, wy_reg, wx0_reg, wx1_reg, wy1_reg;
    logic [CW-1:0] rx_reg, ry_reg;
    logic [23:0]   prgb_reg;
    logic          pwr_reg;
    logic [AW-1:0] pa_reg;
    logic [31:0]   pixel_reg;
    logic          done_reg;
    logic          rd_ok_reg;

    // screen and save memory ports
    logic          s_we;
    logic [AW-1:0] s_wa, s_ra;
    logic [24:0]   s_wd, s_rd;
    logic          v_we;
    logic [AW-1:0] v_wa, v_ra;
    logic [24:0]   v_wd, v_rd;

    gfc_mem #(.AW(AW), .DW(25)) u_screen (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
    gfc_mem #(.AW(AW), .DW(25)) u_saved (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));

    function automatic logic [CW-1:0] clamp_side(input logic [8:0] v);
        logic [CW-1:0] r;
        if (v == 9'd0) r = CW'(1);
        else if ({7'd0, v} > 16'(MAX_SIDE)) r = CW'(MAX_SIDE);
        else r = CW'(v);
        return r;
    endfunction

    function automatic logic [AW-1:0] mk_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return {y[SW-1:0], x[SW-1:0]};
    endfunction

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= clamp_side(9'd256);
            sh_reg <= clamp_side(9'd256);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == gfc_pkg::CFG_WIDTH) sw_reg <= clamp_side(cfg_data);
            else if (cfg_index == gfc_pkg::CFG_HEIGHT) sh_reg <= clamp_side(cfg_data);
        end
    end

    assign busy = (state_reg != S_IDLE);
    wire accept = start && !busy;

    // frame-begin clipping
    logic [16:0] fx1w, fy1w;
    logic [CW-1:0] fx0, fy0, fx1, fy1;
    logic need_disp;
    always_comb
    begin
        fx1w = {1'b0, left} + {1'b0, rect_width};
        fy1w = {1'b0, top} + {1'b0, rect_height};
        fx0 = ({1'b0, left} < 17'(sw_reg)) ? CW'(left) : sw_reg;
        fy0 = ({1'b0, top} < 17'(sh_reg)) ? CW'(top) : sh_reg;
        fx1 = (fx1w < 17'(sw_reg)) ? CW'(fx1w) : sw_reg;
        fy1 = (fy1w < 17'(sh_reg)) ? CW'(fy1w) : sh_reg;
        need_disp = !transparent_index[8] || fx0 != '0 || fx1 != sw_reg
                 || fy0 != '0 || fy1 != sh_reg || disposal == gfc_pkg::DISP_RESTORE;
    end

    // raster pixel decode
    logic [16:0] pxw, pyw;
    logic [8:0]  pidx;
    logic        pix_live, pix_write;
    always_comb
    begin
        pxw = {1'b0, gl_reg} + {1'b0, cx_reg};
        pyw = {1'b0, gt_reg} + {1'b0, cy_reg};
        pidx = ({1'b0, color_index} < plimit_reg) ? {1'b0, color_index} : 9'd0;
        pix_live = gw_reg != 16'd0 && cy_reg < gh_reg;
        pix_write = pix_live && pxw >= 17'(px0_reg) && pxw < 17'(px1_reg)
                 && pyw >= 17'(py0_reg) && pyw < 17'(py1_reg)
                 && $signed(pidx) != tr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == gfc_pkg::KIND_PAL && {1'b0, color_index} < 9'(PALETTE_ENTRIES))
        begin
            pal[PW'(color_index)] <= rgb;
        end
        prgb_reg <= pal[PW'(pidx)];
        pa_reg   <= mk_addr(CW'(pxw), CW'(pyw));
    end

    // memory port control
    logic [AW-1:0] walk_a;
    assign walk_a = mk_addr(wx_reg, wy_reg);
    always_comb
    begin
        s_we = 1'b0; s_wa = walk_a; s_wd = '0; s_ra = walk_a;
        v_we = 1'b0; v_wa = walk_a; v_wd = s_rd; v_ra = walk_a;
        case (state_reg)
            S_INIT:   s_we = 1'b1;
            S_DSP_WR:
            begin
                s_we = 1'b1;
                s_wd = restore_reg ? v_rd : 25'd0;
            end
            S_DSP_RD:
            begin
                if (!restore_reg) s_we = 1'b1;
            end
            S_SAVE_WR: v_we = 1'b1;
            S_PIX:
            begin
                s_we = pwr_reg;
                s_wa = pa_reg;
                s_wd = {1'b1, prgb_reg};
            end
            S_IDLE:   s_ra = mk_addr(rx_reg, ry_reg);
            default:  s_we = 1'b0;
        endcase
        if (state_reg == S_READ) s_ra = mk_addr(rx_reg, ry_reg);
    end

    // step walker over a rectangle; walk_last is 1 on the last point
    logic walk_last;
    assign walk_last = (wx_reg + 1'b1 >= wx1_reg) && (wy_reg + 1'b1 >= wy1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            plimit_reg <= 9'(PALETTE_ENTRIES);
            pdisp_reg <= gfc_pkg::DISP_NONE;
            px0_reg <= '0; py0_reg <= '0; px1_reg <= '0; py1_reg <= '0;
            gl_reg <= '0; gt_reg <= '0; gw_reg <= '0; gh_reg <= '0;
            cx_reg <= '0; cy_reg <= '0;
            tr_reg <= -9'sd1;
            clr_all_reg <= 1'b0; restore_reg <= 1'b0; save_reg <= 1'b0;
            wx_reg <= '0; wy_reg <= '0; wx0_reg <= '0;
            wx1_reg <= CW'(MAX_SIDE); wy1_reg <= CW'(MAX_SIDE);
            rx_reg <= '0; ry_reg <= '0;
            pwr_reg <= 1'b0; pixel_reg <= '0; done_reg <= 1'b0; rd_ok_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    if (walk_last) state_reg <= S_IDLE;
                    else if (wx_reg + 1'b1 >= wx1_reg)
                    begin
                        wx_reg <= '0; wy_reg <= wy_reg + 1'b1;
                    end
                    else wx_reg <= wx_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pixel_reg <= '0;
                        case (kind)
                            gfc_pkg::KIND_PAL: state_reg <= S_DONE;
                            gfc_pkg::KIND_READ:
                            begin
                                rx_reg <= CW'(left); ry_reg <= CW'(top);
                                rd_ok_reg <= {1'b0, left} < 17'(sw_reg)
                                          && {1'b0, top} < 17'(sh_reg);
                                state_reg <= S_READ;
                            end
                            gfc_pkg::KIND_PIX:
                            begin
                                pwr_reg <= pix_write;
                                if (pix_live)
                                begin
                                    if (cx_reg + 16'd1 >= gw_reg)
                                    begin
                                        cx_reg <= '0; cy_reg <= cy_reg + 16'd1;
                                    end
                                    else cx_reg <= cx_reg + 16'd1;
                                end
                                state_reg <= S_PIX;
                            end
                            default:
                            begin
                                // frame begin: dispose of prior frame first
                                clr_all_reg <= need_disp && first_frame;
                                // a whole-store clear never copies from the save memory
                                restore_reg <= pdisp_reg == gfc_pkg::DISP_RESTORE
                                            && !(need_disp && first_frame);
                                save_reg <= disposal == gfc_pkg::DISP_RESTORE && !first_frame;
                                if (need_disp && first_frame)
                                begin
                                    wx_reg <= '0; wy_reg <= '0; wx0_reg <= '0;
                                    wx1_reg <= CW'(MAX_SIDE); wy1_reg <= CW'(MAX_SIDE);
                                    state_reg <= S_DSP_RD;
                                end
                                else if (need_disp && (pdisp_reg == gfc_pkg::DISP_RESTORE
                                         || pdisp_reg == gfc_pkg::DISP_BG)
                                         && px0_reg < px1_reg && py0_reg < py1_reg)
                                begin
                                    wx_reg <= px0_reg; wy_reg <= py0_reg; wx0_reg <= px0_reg;
                                    wx1_reg <= px1_reg; wy1_reg <= py1_reg;
                                    state_reg <= S_DSP_RD;
                                end
                                else if (disposal == gfc_pkg::DISP_RESTORE && !first_frame
                                         && fx0 < fx1 && fy0 < fy1)
                                begin
                                    wx_reg <= fx0; wy_reg <= fy0; wx0_reg <= fx0;
                                    wx1_reg <= fx1; wy1_reg <= fy1;
                                    state_reg <= S_SAVE_RD;
                                end
                                else state_reg <= S_DONE;
                                pdisp_reg <= (disposal == gfc_pkg::DISP_RESTORE && first_frame)
                                           ? gfc_pkg::DISP_BG : disposal;
                                px0_reg <= fx0; py0_reg <= fy0; px1_reg <= fx1; py1_reg <= fy1;
                                gl_reg <= left; gt_reg <= top;
                                gw_reg <= rect_width; gh_reg <= rect_height;
                                cx_reg <= '0; cy_reg <= '0;
                                tr_reg <= transparent_index[8] ? -9'sd1 : transparent_index;
                                plimit_reg <= (color_count < 9'(PALETTE_ENTRIES))
                                            ? color_count : 9'(PALETTE_ENTRIES);
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_DONE;
                end
                S_PIX: state_reg <= S_DONE;
                S_DSP_RD:
                begin
                    if (restore_reg && !clr_all_reg) state_reg <= S_DSP_WR;
                    else if (walk_last) state_reg <= S_DSP_WR;
                    else if (wx_reg + 1'b1 >= wx1_reg)
                    begin
                        wx_reg <= wx0_reg; wy_reg <= wy_reg + 1'b1;
                    end
                    else wx_reg <= wx_reg + 1'b1;
                    if (clr_all_reg) restore_reg <= 1'b0;
                end
                S_DSP_WR:
                begin
                    if (walk_last)
                    begin
                        if (save_reg && px0_reg < px1_reg && py0_reg < py1_reg)
                        begin
                            wx_reg <= px0_reg; wy_reg <= py0_reg; wx0_reg <= px0_reg;
                            wx1_reg <= px1_reg; wy1_reg <= py1_reg;
                            state_reg <= S_SAVE_RD;
                        end
                        else state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (wx_reg + 1'b1 >= wx1_reg)
                        begin
                            wx_reg <= wx0_reg; wy_reg <= wy_reg + 1'b1;
                        end
                        else wx_reg <= wx_reg + 1'b1;
                        state_reg <= S_DSP_RD;
                    end
                end
                S_SAVE_RD: state_reg <= S_SAVE_WR;
                S_SAVE_WR:
                begin
                    if (walk_last) state_reg <= S_DONE;
                    else
                    begin
                        if (wx_reg + 1'b1 >= wx1_reg)
                        begin
                            wx_reg <= wx0_reg; wy_reg <= wy_reg + 1'b1;
                        end
                        else wx_reg <= wx_reg + 1'b1;
                        state_reg <= S_SAVE_RD;
                    end
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    if (rd_ok_reg && s_rd[24])
                        pixel_reg <= gfc_pkg::ALPHA_OPAQUE | {8'd0, s_rd[23:0]};
                    rd_ok_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign pixel = done_reg ? pixel_reg : '0;
    assign done = done_reg;
    assign done_res = done_reg;

`ifndef SYNTHESIS
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("double result");
    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy) else $error("accept not blocked");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE) else $error("result outside idle");
`endif

endmodule

// ===== design/gfc_mem.sv =====
// Synchronous single-write-port, single-read-port memory with a registered read.
// Depends on nothing.
module gfc_mem #(
    parameter int AW = 16,
    parameter int DW = 25
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== dv/tb_gif_frame_compositor_top.sv =====
// Self-checking testbench for gif_frame_compositor_top: directed and random item streams
// checked against an in-bench prediction of the screen, save and palette stores.
// Depends on gfc_pkg and the compositor RTL.
`timescale 1ns / 1ps

module tb_gif_frame_compositor_top;

    typedef struct {
        gfc_pkg::kind_t     kind;
        logic [7:0]         color_index;
        logic [23:0]        rgb;
        logic [15:0]        left;
        logic [15:0]        top;
        logic [15:0]        rect_width;
        logic [15:0]        rect_height;
        gfc_pkg::disp_t     disposal;
        logic signed [8:0]  transparent_index;
        logic               first_frame;
        logic [8:0]         color_count;
    } item_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [7:0]         color_index;
    logic [23:0]        rgb;
    logic [15:0]        left;
    logic [15:0]        top;
    logic [15:0]        rect_width;
    logic [15:0]        rect_height;
    logic [1:0]         disposal;
    logic signed [8:0]  transparent_index;
    logic               first_frame;
    logic [8:0]         color_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [8:0]         cfg_data;
    logic               done;
    logic [31:0]        pixel;
    logic               done_res;

    gif_frame_compositor_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .color_index(color_index), .rgb(rgb), .left(left), .top(top),
        .rect_width(rect_width), .rect_height(rect_height), .disposal(disposal),
        .transparent_index(transparent_index), .first_frame(first_frame),
        .color_count(color_count), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .pixel(pixel),
        .done_res(done_res)
    );

    // predicted compositor state
    logic [24:0]  screen_mem [65536];
    logic [24:0]  saved_mem [65536];
    logic [23:0]  palette [256];
    bit           pal_written [256];
    int unsigned  scr_w, scr_h, pal_limit;
    int unsigned  prev_disp, prev_x0, prev_y0, prev_x1, prev_y1;
    int unsigned  geo_l, geo_t, geo_w, geo_h, cur_x, cur_y;
    int           cur_trans;

    logic [31:0]  expected_pixels [$];
    int           fail_count;
    int           items_sent;
    int           reads_sent;
    int           frames_sent;
    int           first_frames;
    bit           no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned clamp_side(logic [8:0] v);
        if (v < 1) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    // copy (or clear) the prior frame rectangle
    task automatic move_prev_rect(bit to_saved, bit clear);
        for (int unsigned y = prev_y0; y < prev_y1; y++)
            for (int unsigned x = prev_x0; x < prev_x1; x++)
            begin
                if (clear)
                    screen_mem[y * 256 + x] = '0;
                else if (to_saved)
                    saved_mem[y * 256 + x] = screen_mem[y * 256 + x];
                else
                    screen_mem[y * 256 + x] = saved_mem[y * 256 + x];
            end
    endtask

    task automatic apply_item(item_t it, output logic [31:0] px);
        int unsigned x0, y0, x1, y1, idx, x, y, col, row;
        int trans;
        px = '0;
        case (it.kind)
            gfc_pkg::KIND_PAL:
            begin
                palette[it.color_index] = it.rgb;
                pal_written[it.color_index] = 1'b1;
            end
            gfc_pkg::KIND_FRAME:
            begin
                trans = it.transparent_index[8] ? -1 : int'(it.transparent_index[7:0]);
                x0 = (it.left < scr_w) ? it.left : scr_w;
                y0 = (it.top < scr_h) ? it.top : scr_h;
                x1 = (int'(it.left) + int'(it.rect_width) < scr_w) ?
                     it.left + it.rect_width : scr_w;
                y1 = (int'(it.top) + int'(it.rect_height) < scr_h) ?
                     it.top + it.rect_height : scr_h;
                if (trans >= 0 || x0 > 0 || x1 < scr_w || y0 > 0 || y1 < scr_h ||
                    it.disposal == gfc_pkg::DISP_RESTORE)
                begin
                    if (it.first_frame)
                        foreach (screen_mem[i]) screen_mem[i] = '0;
                    else if (prev_disp == gfc_pkg::DISP_RESTORE)
                        move_prev_rect(1'b0, 1'b0);
                    else if (prev_disp == gfc_pkg::DISP_BG)
                        move_prev_rect(1'b0, 1'b1);
                end
                prev_disp = it.disposal;
                prev_x0 = x0; prev_y0 = y0; prev_x1 = x1; prev_y1 = y1;
                if (it.disposal == gfc_pkg::DISP_RESTORE)
                begin
                    if (it.first_frame) prev_disp = gfc_pkg::DISP_BG;
                    else move_prev_rect(1'b1, 1'b0);
                end
                geo_l = it.left; geo_t = it.top;
                geo_w = it.rect_width; geo_h = it.rect_height;
                cur_x = 0; cur_y = 0;
                cur_trans = trans;
                pal_limit = (it.color_count < 256) ? it.color_count : 256;
            end
            gfc_pkg::KIND_PIX:
            begin
                if (geo_w != 0 && cur_y < geo_h)
                begin
                    x = geo_l + cur_x;
                    y = geo_t + cur_y;
                    idx = (it.color_index < pal_limit) ? it.color_index : 0;
                    if (x >= prev_x0 && x < prev_x1 && y >= prev_y0 && y < prev_y1 &&
                        int'(idx) != cur_trans)
                        screen_mem[y * 256 + x] = {1'b1, palette[idx]};
                    cur_x++;
                    if (cur_x >= geo_w)
                    begin
                        cur_x = 0;
                        cur_y++;
                    end
                end
            end
            default:
            begin
                col = it.left;
                row = it.top;
                if (col < scr_w && row < scr_h && screen_mem[row * 256 + col][24])
                    px = gfc_pkg::ALPHA_OPAQUE | {8'h00, screen_mem[row * 256 + col][23:0]};
            end
        endcase
    endtask

    // result checker: one result per item, in order
    always @(posedge clk)
    begin
        logic [31:0] exp_px;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("result with nothing expected: pixel %h", pixel);
                fail_count++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (pixel !== exp_px)
                begin
                    $error("pixel mismatch: expected %h actual %h", exp_px, pixel);
                    fail_count++;
                end
                if (done_res !== 1'b1)
                begin
                    $error("done_res mismatch: expected 1 actual %b", done_res);
                    fail_count++;
                end
            end
        end
    end

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called right after a rising edge; returns right after the accepting edge (or gap)
    task automatic send_item(item_t it);
        logic [31:0] px;
        int g;
        start             <= 1'b1;
        kind              <= it.kind;
        color_index       <= it.color_index;
        rgb               <= it.rgb;
        left              <= it.left;
        top               <= it.top;
        rect_width        <= it.rect_width;
        rect_height       <= it.rect_height;
        disposal          <= it.disposal;
        transparent_index <= it.transparent_index;
        first_frame       <= it.first_frame;
        color_count       <= it.color_count;
        @(posedge clk);
        while (busy) @(posedge clk);
        apply_item(it, px);
        expected_pixels.push_back(px);
        items_sent++;
        if (it.kind == gfc_pkg::KIND_READ) reads_sent++;
        if (it.kind == gfc_pkg::KIND_FRAME) frames_sent++;
        g = gap_len();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [8:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == gfc_pkg::CFG_WIDTH) scr_w = clamp_side(val);
        else scr_h = clamp_side(val);
    endtask

    function automatic item_t blank(gfc_pkg::kind_t k);
        item_t it;
        it = '{kind: k, color_index: 8'd0, rgb: 24'd0, left: 16'd0, top: 16'd0,
               rect_width: 16'd0, rect_height: 16'd0, disposal: gfc_pkg::DISP_NONE,
               transparent_index: -9'sd1, first_frame: 1'b0, color_count: 9'd256};
        return it;
    endfunction

    function automatic item_t pal_item(logic [7:0] slot, logic [23:0] color);
        item_t it;
        it = blank(gfc_pkg::KIND_PAL);
        it.color_index = slot;
        it.rgb = color;
        return it;
    endfunction

    function automatic item_t pix_item(logic [7:0] ci);
        item_t it;
        it = blank(gfc_pkg::KIND_PIX);
        it.color_index = ci;
        return it;
    endfunction

    function automatic item_t read_item(logic [15:0] col, logic [15:0] row);
        item_t it;
        it = blank(gfc_pkg::KIND_READ);
        it.left = col;
        it.top = row;
        return it;
    endfunction

    function automatic item_t frame_item(logic [15:0] l, logic [15:0] t, logic [15:0] w,
                                         logic [15:0] h, gfc_pkg::disp_t d,
                                         logic signed [8:0] tr, logic first,
                                         logic [8:0] cnt);
        item_t it;
        it = blank(gfc_pkg::KIND_FRAME);
        it.left = l; it.top = t; it.rect_width = w; it.rect_height = h;
        it.disposal = d; it.transparent_index = tr; it.first_frame = first;
        it.color_count = cnt;
        return it;
    endfunction

    // raster index whose color is known (or that is transparent)
    function automatic logic [7:0] pick_index();
        int unsigned idx, eff;
        for (int n = 0; n < 10; n++)
        begin
            idx = $urandom_range(0, 255);
            eff = (idx < pal_limit) ? idx : 0;
            if (pal_written[eff] || int'(eff) == cur_trans) return idx;
        end
        return 8'd0;
    endfunction

    function automatic logic signed [8:0] pick_trans();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return -9'sd1;
        if (r == 4) return -9'sd256;
        if (r == 5) return $signed(9'h100 | 9'($urandom_range(0, 255)));
        return $signed({1'b0, 8'($urandom_range(0, 255))});
    endfunction

    task automatic test_config_extremes();
        write_cfg(gfc_pkg::CFG_WIDTH, 9'd0);
        write_cfg(gfc_pkg::CFG_HEIGHT, 9'd511);
        send_item(read_item(16'd0, 16'd0));
        send_item(read_item(16'd1, 16'd0));
        write_cfg(gfc_pkg::CFG_WIDTH, 9'd256);
        write_cfg(gfc_pkg::CFG_HEIGHT, 9'd256);
    endtask

    task automatic test_directed_frames();
        send_item(pal_item(8'd0, 24'h000000));
        send_item(pal_item(8'd255, 24'hffffff));
        send_item(pal_item(8'd5, 24'h123456));
        // first frame with transparency: whole-store clear
        send_item(frame_item(16'd0, 16'd0, 16'd4, 16'd2, gfc_pkg::DISP_BG, 9'sd5, 1'b1,
                             9'd256));
        send_item(pix_item(8'd255));
        send_item(pix_item(8'd5));
        send_item(pix_item(8'd0));
        send_item(pix_item(8'd255));
        repeat (4) send_item(pix_item(8'd255));
        send_item(pix_item(8'd5)); // past the last row
        send_item(read_item(16'd0, 16'd0));
        send_item(read_item(16'd1, 16'd0));
        send_item(read_item(16'd255, 16'd255));
        send_item(read_item(16'd256, 16'd0));
        // fully off-screen restore frame; count 1 makes index 200 fold to 0
        send_item(frame_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, gfc_pkg::DISP_RESTORE,
                             9'sd255, 1'b0, 9'd1));
        send_item(pix_item(8'd200));
        send_item(frame_item(16'd2, 16'd1, 16'd3, 16'd2, gfc_pkg::DISP_KEEP, -9'sd256, 1'b0,
                             9'd256));
        send_item(pix_item(8'd5));
        send_item(pix_item(8'd255));
        send_item(read_item(16'd2, 16'd1));
        send_item(read_item(16'd3, 16'd1));
        send_item(read_item(16'd0, 16'd1));
    endtask

    task automatic random_frame();
        item_t fr;
        int unsigned w, h, npix;
        bit first;
        first = (first_frames < 5) && ($urandom_range(0, 60) == 0);
        if (first) first_frames++;
        w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 10);
        h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8);
        fr = frame_item(
            ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, scr_w + 2)),
            ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, scr_h + 2)),
            16'(w), 16'(h), gfc_pkg::disp_t'($urandom_range(0, 3)), pick_trans(), first,
            ($urandom_range(0, 3) == 0) ? 9'($urandom_range(1, 256)) : 9'd256);
        send_item(fr);
        npix = (w > 12 || h > 12) ? $urandom_range(0, 40) : w * h + $urandom_range(0, 3);
        for (int n = 0; n < npix; n++)
        begin
            case ($urandom_range(0, 19))
                0: send_item(pal_item(8'($urandom), 24'($urandom)));
                1, 2: send_item(read_item(16'($urandom_range(0, scr_w)),
                                          16'($urandom_range(0, scr_h))));
                default: ;
            endcase
            send_item(pix_item(pick_index()));
        end
        repeat ($urandom_range(0, 3))
            send_item(read_item(16'($urandom_range(0, scr_w)), 16'($urandom_range(0, scr_h))));
    endtask

    task automatic test_random_animation();
        int r;
        for (int i = 0; i < 32; i++) send_item(pal_item(8'($urandom), 24'($urandom)));
        while (items_sent < 1950)
        begin
            r = $urandom_range(0, 9);
            write_cfg(gfc_pkg::CFG_WIDTH, (r == 0) ? 9'd511 : (r == 1) ? 9'd1 :
                      (r == 2) ? 9'd256 : 9'($urandom_range(0, 24)));
            r = $urandom_range(0, 9);
            write_cfg(gfc_pkg::CFG_HEIGHT, (r == 0) ? 9'd511 : (r == 1) ? 9'd0 :
                      (r == 2) ? 9'd256 : 9'($urandom_range(1, 24)));
            repeat ($urandom_range(3, 8))
            begin
                no_idle = ($urandom_range(0, 3) == 0);
                random_frame();
                if ($urandom_range(0, 7) == 0)
                    send_item(read_item(16'($urandom), 16'($urandom)));
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        start = 1'b0; kind = gfc_pkg::KIND_PAL; color_index = '0; rgb = '0;
        left = '0; top = '0; rect_width = '0; rect_height = '0;
        disposal = gfc_pkg::DISP_NONE;
        transparent_index = -9'sd1; first_frame = 1'b0; color_count = 9'd256;
        cfg_valid = 1'b0; cfg_index = gfc_pkg::CFG_WIDTH; cfg_data = '0;
        fail_count = 0; items_sent = 0; reads_sent = 0; frames_sent = 0;
        first_frames = 1; no_idle = 1'b0;
        foreach (screen_mem[i]) screen_mem[i] = '0;
        foreach (saved_mem[i]) saved_mem[i] = '0;
        foreach (palette[i]) palette[i] = '0;
        foreach (pal_written[i]) pal_written[i] = 1'b0;
        scr_w = 256; scr_h = 256; pal_limit = 256; prev_disp = 0;
        prev_x0 = 0; prev_y0 = 0; prev_x1 = 0; prev_y1 = 0;
        geo_l = 0; geo_t = 0; geo_w = 0; geo_h = 0; cur_x = 0; cur_y = 0; cur_trans = -1;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_config_extremes();
        test_directed_frames();
        test_random_animation();

        drain();
        repeat (50) @(posedge clk);
        $display("Covered %0d items: %0d frame begins (%0d first frames), %0d reads.",
                 items_sent, frames_sent, first_frames, reads_sent);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== gif_frame_compositor_top.f =====
design/gfc_pkg.sv
design/gfc_mem.sv
design/gif_frame_compositor_top.sv
dv/tb_gif_frame_compositor_top.sv
